### design/c2s_pkg.sv
// ----------------------------------------------------------------------------
// c2s_pkg - shared types and constants of the Cartesian to spherical converter
// Widths, the CORDIC arctangent table and one step of the square root.
// ----------------------------------------------------------------------------
package c2s_pkg;

	localparam int COORD_WIDTH  = 16;
	localparam int ANGLE_WIDTH  = 16;
	localparam int CORDIC_STEPS = 16;

	// datapath and accumulator widths
	localparam int DP_W    = 64;
	localparam int ACC_W   = 34;
	localparam int STEP_W  = 5;
	localparam int SUM_W   = 2 * COORD_WIDTH;

	// square root: 64-bit radicand, 32 steps, two per stage
	localparam int RAD_W     = 64;
	localparam int ROOT_W    = 32;
	localparam int REM_W     = 34;
	localparam int SQ_PER    = 2;
	localparam int SQ_STAGES = ROOT_W / SQ_PER;

	// CORDIC operand pre-scale (x * 2^(60-CW))
	localparam int PRE_SH  = 60 - COORD_WIDTH;
	localparam int RXY_SH  = 28;

	typedef logic signed [DP_W-1:0]  dp_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	localparam acc_t HALF_TURN = acc_t'(64'h0000_0000_8000_0000);

	typedef struct packed {
		dp_t  x;
		dp_t  y;
		acc_t ang;
	} cordic_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	// atan(2^-i) in 2^32-per-turn units
	function automatic acc_t atan_entry(input logic [STEP_W-1:0] i);
		logic [31:0] v;
		case (i)
			5'd0:    v = 32'h20000000;
			5'd1:    v = 32'h12E4051E;
			5'd2:    v = 32'h09FB385B;
			5'd3:    v = 32'h051111D4;
			5'd4:    v = 32'h028B0D43;
			5'd5:    v = 32'h0145D7E1;
			5'd6:    v = 32'h00A2F61E;
			5'd7:    v = 32'h00517C55;
			5'd8:    v = 32'h0028BE53;
			5'd9:    v = 32'h00145F2F;
			5'd10:   v = 32'h000A2F98;
			5'd11:   v = 32'h000517CC;
			5'd12:   v = 32'h00028BE6;
			5'd13:   v = 32'h000145F3;
			5'd14:   v = 32'h0000A2FA;
			5'd15:   v = 32'h0000517D;
			5'd16:   v = 32'h000028BE;
			5'd17:   v = 32'h0000145F;
			5'd18:   v = 32'h00000A30;
			5'd19:   v = 32'h00000518;
			5'd20:   v = 32'h0000028C;
			5'd21:   v = 32'h00000146;
			5'd22:   v = 32'h000000A3;
			5'd23:   v = 32'h00000051;
			5'd24:   v = 32'h00000029;
			5'd25:   v = 32'h00000014;
			5'd26:   v = 32'h0000000A;
			5'd27:   v = 32'h00000005;
			5'd28:   v = 32'h00000003;
			5'd29:   v = 32'h00000001;
			5'd30:   v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return acc_t'(v);
	endfunction

	// one restoring square-root step on the next radicand bit pair
	function automatic sq_t sqrt_iter(input sq_t s, input logic [1:0] pair);
		logic [REM_W+1:0] cur;
		logic [REM_W+1:0] trial;
		sq_t o;
		cur   = {s.rem, pair};
		trial = (REM_W+2)'({s.root, 2'b01});
		if (cur >= trial) begin
			o.rem  = REM_W'(cur - trial);
			o.root = {s.root[ROOT_W-2:0], 1'b1};
		end else begin
			o.rem  = REM_W'(cur);
			o.root = {s.root[ROOT_W-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage

### design/cartesian_to_spherical.sv
// ----------------------------------------------------------------------------
// cartesian_to_spherical - pipelined Cartesian to spherical converter
// Radius by digit-by-digit square root, both angles by vectoring CORDIC.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one point x_coord, y_coord,
//   z_coord per beat. Output channel (out_valid / out_stall) gives radius,
//   azimuth and polar_angle per beat, in input order.
//   The pipeline has one register for the squares, 16 square-root stages (two
//   root bits per stage on a 64-bit radicand), one CORDIC setup stage,
//   16 CORDIC stages and the output register. Throughput is one point
//   per cycle unless the output stalls; every stage holds one point.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   in_stall is raised; nothing is lost or repeated, and bubbles still
//   move forward whenever the output beat is taken.
//   Angles: 65536 is one full turn. Azimuth is 0 when x = y = 0, polar
//   angle is 0 at the origin and is clamped to [0, half turn].
//   Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module cartesian_to_spherical (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [c2s_pkg::COORD_WIDTH-1:0] x_coord,
	input  logic signed [c2s_pkg::COORD_WIDTH-1:0] y_coord,
	input  logic signed [c2s_pkg::COORD_WIDTH-1:0] z_coord,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [c2s_pkg::COORD_WIDTH-1:0]        radius,
	output logic [c2s_pkg::ANGLE_WIDTH-1:0]        azimuth,
	output logic [c2s_pkg::ANGLE_WIDTH-1:0]        polar_angle
);
	import c2s_pkg::*;

	localparam int RND_SH = (ANGLE_WIDTH < 32) ? (31 - ANGLE_WIDTH) : 0;
	localparam logic [31:0] ANG_RND = (ANGLE_WIDTH < 32) ? (32'd1 << RND_SH) : 32'd0;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic signed [COORD_WIDTH-1:0] z;
		logic                          xy_nz;
		logic                          s3_nz;
	} side_t;

	typedef struct packed {
		logic [COORD_WIDTH-1:0] rad;
		logic                   xy_nz;
		logic                   s3_nz;
	} cside_t;

	logic adv;
	logic out_valid_q;

	// whole pipe advances unless a finished beat is held
	assign adv      = ~(out_valid_q & out_stall);
	assign in_stall = ~adv;

	// ---------------------------------------------------------------- squares
	logic                    vld_s1;
	side_t                   side_s1;
	logic [SUM_W-1:0]        sxy_s1;
	logic [SUM_W-1:0]        s3_s1;
	logic signed [SUM_W-1:0] xx, yy, zz;
	logic [SUM_W-1:0]        sxy_c, s3_c;

	always_comb begin
		xx    = SUM_W'(x_coord * x_coord);
		yy    = SUM_W'(y_coord * y_coord);
		zz    = SUM_W'(z_coord * z_coord);
		sxy_c = SUM_W'(xx) + SUM_W'(yy);
		s3_c  = sxy_c + SUM_W'(zz);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.x     <= x_coord;
			side_s1.y     <= y_coord;
			side_s1.z     <= z_coord;
			side_s1.xy_nz <= (x_coord != '0) || (y_coord != '0);
			side_s1.s3_nz <= (x_coord != '0) || (y_coord != '0) || (z_coord != '0);
			sxy_s1        <= sxy_c;
			s3_s1         <= s3_c;
		end
	end

	// ------------------------------------------------------------ square roots
	// index 0 is the squares stage; radius radicand s3, planar one sxy << (RAD_W - SUM_W)
	logic             sq_vld_s  [0:SQ_STAGES];
	side_t            sq_side_s [0:SQ_STAGES];
	logic [RAD_W-1:0] rad_r_s   [0:SQ_STAGES];
	logic [RAD_W-1:0] rad_p_s   [0:SQ_STAGES];
	sq_t              sq_r_s    [0:SQ_STAGES];
	sq_t              sq_p_s    [0:SQ_STAGES];

	assign sq_vld_s[0]  = vld_s1;
	assign sq_side_s[0] = side_s1;
	assign rad_r_s[0]   = RAD_W'(s3_s1);
	assign rad_p_s[0]   = {sxy_s1, {(RAD_W-SUM_W){1'b0}}};
	assign sq_r_s[0]    = '0;
	assign sq_p_s[0]    = '0;

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
		localparam int HI = RAD_W - 1 - 2 * SQ_PER * k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_vld_s[k+1] <= 1'b0;
			else if (adv) sq_vld_s[k+1] <= sq_vld_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_side_s[k+1] <= sq_side_s[k];
				rad_r_s[k+1]   <= rad_r_s[k];
				rad_p_s[k+1]   <= rad_p_s[k];
				sq_r_s[k+1]    <= sqrt_iter(sqrt_iter(sq_r_s[k], rad_r_s[k][HI -: 2]),
					rad_r_s[k][HI-2 -: 2]);
				sq_p_s[k+1]    <= sqrt_iter(sqrt_iter(sq_p_s[k], rad_p_s[k][HI -: 2]),
					rad_p_s[k][HI-2 -: 2]);
			end
		end
	end

	// ------------------------------------------------------------ CORDIC setup
	side_t                sd;
	logic [ROOT_W:0]      r_inc;
	logic [ROOT_W-1:0]    r_fin;
	cordic_t              az_init, pol_init;
	dp_t                  ax, ay, px, py;

	always_comb begin
		sd    = sq_side_s[SQ_STAGES];
		// round to nearest: bump when remainder exceeds root
		r_inc = (ROOT_W+1)'(sq_r_s[SQ_STAGES].root) + (ROOT_W+1)'(1);
		r_fin = (sq_r_s[SQ_STAGES].rem > REM_W'(sq_r_s[SQ_STAGES].root)) ?
			ROOT_W'(r_inc) : sq_r_s[SQ_STAGES].root;

		ax = DP_W'(sd.x) <<< PRE_SH;
		ay = DP_W'(sd.y) <<< PRE_SH;
		px = DP_W'(sd.z) <<< PRE_SH;
		py = dp_t'({{(DP_W-ROOT_W){1'b0}}, sq_p_s[SQ_STAGES].root}) <<< RXY_SH;

		// left half plane: flip into the right half, start at half a turn
		if (ax[DP_W-1]) begin
			az_init.x   = -ax;
			az_init.y   = -ay;
			az_init.ang = HALF_TURN;
		end else begin
			az_init.x   = ax;
			az_init.y   = ay;
			az_init.ang = '0;
		end
		if (px[DP_W-1]) begin
			pol_init.x   = -px;
			pol_init.y   = -py;
			pol_init.ang = HALF_TURN;
		end else begin
			pol_init.x   = px;
			pol_init.y   = py;
			pol_init.ang = '0;
		end
	end

	// ----------------------------------------------------------- CORDIC stages
	logic    cv_s   [0:CORDIC_STEPS];
	cside_t  cs_s   [0:CORDIC_STEPS];
	cordic_t caz_s  [0:CORDIC_STEPS];
	cordic_t cpol_s [0:CORDIC_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cv_s[0] <= 1'b0;
		else if (adv) cv_s[0] <= sq_vld_s[SQ_STAGES];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cs_s[0].rad   <= COORD_WIDTH'(r_fin);
			cs_s[0].xy_nz <= sd.xy_nz;
			cs_s[0].s3_nz <= sd.s3_nz;
			caz_s[0]      <= az_init;
			cpol_s[0]     <= pol_init;
		end
	end

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cv_s[k+1] <= 1'b0;
			else if (adv) cv_s[k+1] <= cv_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) cs_s[k+1] <= cs_s[k];
		end

		c2s_cordic_stage u_az (
			.clk  (clk),
			.en   (adv),
			.step (STEP_W'(k)),
			.d    (caz_s[k]),
			.q    (caz_s[k+1])
		);

		c2s_cordic_stage u_pol (
			.clk  (clk),
			.en   (adv),
			.step (STEP_W'(k)),
			.d    (cpol_s[k]),
			.q    (cpol_s[k+1])
		);
	end

	// ----------------------------------------------------------------- output
	logic [COORD_WIDTH-1:0] radius_q;
	logic [ANGLE_WIDTH-1:0] azimuth_q;
	logic [ANGLE_WIDTH-1:0] polar_q;
	acc_t                   pol_cl;
	logic [31:0]            az_rnd, pol_rnd;

	always_comb begin
		// polar clamp to [0, half turn]
		pol_cl = cpol_s[CORDIC_STEPS].ang;
		if (pol_cl[ACC_W-1]) pol_cl = '0;
		else if (pol_cl > HALF_TURN) pol_cl = HALF_TURN;
		az_rnd  = caz_s[CORDIC_STEPS].ang[31:0] + ANG_RND;
		pol_rnd = pol_cl[31:0] + ANG_RND;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= cv_s[CORDIC_STEPS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			radius_q  <= cs_s[CORDIC_STEPS].rad;
			azimuth_q <= cs_s[CORDIC_STEPS].xy_nz ? az_rnd[31 -: ANGLE_WIDTH] : '0;
			polar_q   <= cs_s[CORDIC_STEPS].s3_nz ? pol_rnd[31 -: ANGLE_WIDTH] : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign radius      = radius_q;
	assign azimuth     = azimuth_q;
	assign polar_angle = polar_q;

`ifndef SYNTH
	// polar angle never passes half a turn
	a_polar_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (polar_angle <= (ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1))))
		else $error("polar angle above half turn");

	// zero radius only at the origin, where both angles are zero
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && radius == '0) |-> (azimuth == '0 && polar_angle == '0))
		else $error("origin angles not zero");

	// a held pipeline keeps its last CORDIC stage in place
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(cv_s[CORDIC_STEPS]))
		else $error("pipeline moved while stalled");
`endif

endmodule

### design/c2s_cordic_stage.sv
// ----------------------------------------------------------------------------
// c2s_cordic_stage - one registered vectoring CORDIC iteration
// Rotates toward y = 0 by atan(2^-step) and updates the angle accumulator.
// ----------------------------------------------------------------------------
module c2s_cordic_stage (
	input  logic                     clk,
	input  logic                     en,
	input  logic [c2s_pkg::STEP_W-1:0] step,
	input  c2s_pkg::cordic_t         d,
	output c2s_pkg::cordic_t         q
);
	import c2s_pkg::*;

	cordic_t nxt;
	dp_t     dx;
	dp_t     dy;
	acc_t    da;

	// direction from the sign of y; y = 0 counts as positive
	always_comb begin
		dx = d.y >>> step;
		dy = d.x >>> step;
		da = atan_entry(step);
		if (d.y[DP_W-1]) begin
			nxt.x   = d.x - dx;
			nxt.y   = d.y + dy;
			nxt.ang = d.ang - da;
		end else begin
			nxt.x   = d.x + dx;
			nxt.y   = d.y - dy;
			nxt.ang = d.ang + da;
		end
	end

	always_ff @(posedge clk) begin
		if (en) q <= nxt;
	end

endmodule
